[rtl/amis_pkg.sv]
// Shared types, constants and the tangent table builder for the angular intra mode search.
// Used by amis_ram and angular_intra_mode_search; depends on nothing else.
package amis_pkg;

    // Default geometry of the search
    localparam int BlockSizeDefault = 16;
    localparam int ModeCountDefault = 32;

    // Sample, coefficient and cost widths
    localparam int SampleW    = 8;
    localparam int IndexW     = 8;
    localparam int FracBits   = 16;
    localparam int TanW       = 24;
    localparam int CostW      = 16;
    localparam int ModeFieldW = 5;

    localparam logic [CostW-1:0] CostMax = '1;

    // Fixed-point constants of the tangent table (Q30 angles, Q16 results)
    localparam longint PiQ30    = 64'sd3373259426;
    localparam longint OneQ30   = 64'sd1073741824;
    localparam longint Q16One   = 64'sd65536;
    localparam longint TanLimit = 64 * Q16One;

    // Request word kinds
    typedef enum logic [1:0] {
        KIND_NEIGHBOR = 2'd0,
        KIND_SOURCE   = 2'd1,
        KIND_START    = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [IndexW-1:0]   index;
        logic [SampleW-1:0]  value;
    } req_word_t;

    typedef struct packed {
        logic [ModeFieldW-1:0] best_mode;
        logic [CostW-1:0]      best_cost;
    } rsp_word_t;

    // Search sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_COT,
        ST_MUL_TAN,
        ST_ADDR,
        ST_ACC,
        ST_MODE_END
    } state_t;

    // Truncating quotient of a non-negative numerator by a positive divisor.
    // Shift and subtract; only used while the table is built.
    function automatic longint udiv(longint num, longint den);
        longint q;
        longint rem;
        q = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // tan of a reduced angle x (Q30 radians, 0..pi/2) as signed Q16, clamped to +-64.
    // Evaluated at elaboration only; sin and cos come from truncating Taylor series.
    function automatic longint tan_q16(longint x, bit at_quarter, bit neg);
        longint x2;
        longint term;
        longint s;
        longint c;
        longint r;
        if (x == 0)
        begin
            return 0;
        end
        if (at_quarter)
        begin
            return neg ? -TanLimit : TanLimit;
        end
        x2 = (x * x) / OneQ30;
        // sine series
        s = 0;
        term = x;
        for (int n = 1; n <= 21; n += 2)
        begin
            if ((((n - 1) / 2) % 2) == 0)
                s = s + term;
            else
                s = s - term;
            term = (term * x2) / OneQ30;
            term = udiv(term, longint'(n + 1) * longint'(n + 2));
        end
        // cosine series
        c = 0;
        term = OneQ30;
        for (int n = 0; n <= 20; n += 2)
        begin
            if (((n / 2) % 2) == 0)
                c = c + term;
            else
                c = c - term;
            term = (term * x2) / OneQ30;
            term = udiv(term, longint'(n + 1) * longint'(n + 2));
        end
        if (s < 0)
            s = 0;
        if ((c <= 0) || (s >= 64 * c))
        begin
            r = TanLimit;
        end
        else
        begin
            r = udiv(s * Q16One + c / 2, c);
            if (r > TanLimit)
                r = TanLimit;
        end
        return neg ? -r : r;
    endfunction

endpackage

[rtl/amis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on amis_pkg for default sizes only.
module amis_ram #(
    parameter int WIDTH = amis_pkg::SampleW,
    parameter int DEPTH = 4 * amis_pkg::BlockSizeDefault
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/angular_intra_mode_search.sv]
// Angular intra mode search: picks the angular mode with the lowest SAD for one block.
// Depends on amis_pkg and amis_ram.
//
// Usage:
//   Request channel (req_valid / req_stall / req_word) carries one word per transfer.
//   Kind NEIGHBOR writes neighbor sample [index], kind SOURCE writes source pixel
//   [index = y*BLOCK_SIZE + x]; out-of-range writes are dropped. Load words are taken
//   one per cycle whenever the search is idle, also while a result waits.
//   Kind START runs the search and yields one response word (best_mode, best_cost).
//   For each pixel the sequencer steps through the single shared coefficient multiplier
//   (ST_MUL_COT, then ST_MUL_TAN), the sample RAM reads (ST_ADDR) and the SAD
//   accumulate (ST_ACC); each mode ends with a compare (ST_MODE_END). req_stall stays
//   high while a search runs, from acceptance of the START word to the response.
//   The response sits in an output register until taken; a START word is held off
//   while a response is still pending, load words are not.
//   Reset clears the sequencer, the pending response and the running best
//   (mode 0, cost all ones); the sample RAMs are not cleared and must be written
//   before they are used.
module angular_intra_mode_search #(
    parameter int BLOCK_SIZE = amis_pkg::BlockSizeDefault,
    parameter int MODE_COUNT = amis_pkg::ModeCountDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  amis_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output amis_pkg::rsp_word_t rsp_word
);

    localparam int NbDepth  = 4 * BLOCK_SIZE;
    localparam int SrcDepth = BLOCK_SIZE * BLOCK_SIZE;
    localparam int NbAw     = $clog2(NbDepth);
    localparam int SrcAw    = $clog2(SrcDepth);
    localparam int CoordW   = $clog2(BLOCK_SIZE);
    localparam int ModeW    = $clog2(MODE_COUNT);
    localparam int TanW     = amis_pkg::TanW;
    localparam int ProdW    = CoordW + 1 + TanW;
    localparam int IdxW     = CoordW + 10;
    localparam int SumW     = $clog2(SrcDepth * 255 + 1);
    localparam int SampleW  = amis_pkg::SampleW;
    localparam int CostW    = amis_pkg::CostW;
    localparam int MfW      = amis_pkg::ModeFieldW;
    localparam int FracBits = amis_pkg::FracBits;
    localparam int Period   = 4 * MODE_COUNT;
    localparam int Quarter  = 2 * MODE_COUNT;

    localparam logic [CoordW-1:0]      CoordLast = CoordW'(BLOCK_SIZE - 1);
    localparam logic [ModeW-1:0]       ModeLast  = ModeW'(MODE_COUNT - 1);
    localparam logic signed [IdxW-1:0] TwoN      = IdxW'(2 * BLOCK_SIZE);
    localparam logic signed [IdxW-1:0] TwoNLast  = IdxW'(2 * BLOCK_SIZE - 1);
    localparam logic signed [IdxW-1:0] NbLast    = IdxW'(NbDepth - 1);

    // ------------------------------------------------------------------
    // Per-mode tan / cot table, built at elaboration
    // ------------------------------------------------------------------
    logic signed [TanW-1:0] tan_rom [MODE_COUNT];
    logic signed [TanW-1:0] cot_rom [MODE_COUNT];

    for (genvar m = 0; m < MODE_COUNT; m++)
    begin : g_rom
        localparam int TnK = 4 * m - MODE_COUNT;
        localparam int CtK = Quarter - TnK;
        localparam int TnM = TnK % Period;
        localparam int CtM = CtK % Period;
        localparam int TnR = (TnM <= -Quarter) ? TnM + Period :
                             ((TnM > Quarter) ? TnM - Period : TnM);
        localparam int CtR = (CtM <= -Quarter) ? CtM + Period :
                             ((CtM > Quarter) ? CtM - Period : CtM);
        localparam int TnA = (TnR < 0) ? -TnR : TnR;
        localparam int CtA = (CtR < 0) ? -CtR : CtR;
        localparam longint TnX = (longint'(TnA) * amis_pkg::PiQ30) / Period;
        localparam longint CtX = (longint'(CtA) * amis_pkg::PiQ30) / Period;
        localparam longint TnV = amis_pkg::tan_q16(TnX, TnA == Quarter, TnR < 0);
        localparam longint CtV = amis_pkg::tan_q16(CtX, CtA == Quarter, CtR < 0);
        assign tan_rom[m] = TanW'(TnV);
        assign cot_rom[m] = TanW'(CtV);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    amis_pkg::state_t state_reg, state_next;

    logic [ModeW-1:0]        mode_reg, mode_next;
    logic [CoordW-1:0]       x_reg, x_next;
    logic [CoordW-1:0]       y_reg, y_next;
    logic [SrcAw-1:0]        pix_reg, pix_next;
    logic signed [ProdW-1:0] prod_reg, prod_next;
    logic signed [IdxW-1:0]  i0_reg, i0_next;
    logic [SumW-1:0]         sum_reg, sum_next;
    logic [MfW-1:0]          best_mode_reg, best_mode_next;
    logic [CostW-1:0]        best_cost_reg, best_cost_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    amis_pkg::rsp_word_t     rsp_word_reg, rsp_word_next;

    // ------------------------------------------------------------------
    // Handshake decode
    // ------------------------------------------------------------------
    logic req_accept;
    logic start_take;
    logic nb_wr_en;
    logic src_wr_en;

    assign req_accept = req_valid && !req_stall;
    assign start_take = req_accept && (req_word.kind == amis_pkg::KIND_START);
    assign nb_wr_en   = req_accept && (req_word.kind == amis_pkg::KIND_NEIGHBOR)
                        && (32'(req_word.index) < NbDepth);
    assign src_wr_en  = req_accept && (req_word.kind == amis_pkg::KIND_SOURCE)
                        && (32'(req_word.index) < SrcDepth);

    // ------------------------------------------------------------------
    // Shared multiplier: coordinate times cot or tan of the current mode
    // ------------------------------------------------------------------
    logic                    mul_tan_sel;
    logic [CoordW-1:0]       mul_coord;
    logic signed [TanW-1:0]  mul_coef;
    logic signed [ProdW-1:0] mul_out;

    assign mul_coord = mul_tan_sel ? x_reg : y_reg;
    assign mul_coef  = mul_tan_sel ? tan_rom[mode_reg] : cot_rom[mode_reg];
    assign mul_out   = signed'({1'b0, mul_coord}) * mul_coef;

    // product truncated toward zero to an integer offset
    logic                   round_up;
    logic signed [IdxW-1:0] prod_trunc;

    assign round_up   = prod_reg[ProdW-1] && (prod_reg[FracBits-1:0] != '0);
    assign prod_trunc = IdxW'(prod_reg >>> FracBits) + {{(IdxW-1){1'b0}}, round_up};

    // ------------------------------------------------------------------
    // Neighbor index selection
    // ------------------------------------------------------------------
    logic signed [IdxW-1:0] x_s;
    logic signed [IdxW-1:0] y_s;
    logic signed [IdxW-1:0] i1;
    logic signed [IdxW-1:0] idx_top;
    logic signed [IdxW-1:0] idx_left;
    logic signed [IdxW-1:0] nb_idx;
    logic                   i0_on_top;

    assign x_s       = IdxW'({1'b0, x_reg});
    assign y_s       = IdxW'({1'b0, y_reg});
    assign i1        = y_s - prod_trunc;
    assign idx_top   = TwoN + i0_reg;
    assign idx_left  = TwoN - i1;
    assign i0_on_top = (i0_reg >= 0) && (i0_reg <= TwoNLast);

    always_comb
    begin
        if (i0_on_top)
            nb_idx = idx_top;
        else if (idx_left < 0)
            nb_idx = '0;
        else if (idx_left > NbLast)
            nb_idx = NbLast;
        else
            nb_idx = idx_left;
    end

    // ------------------------------------------------------------------
    // Sample stores
    // ------------------------------------------------------------------
    logic               rd_issue;
    logic [SampleW-1:0] nb_sample;
    logic [SampleW-1:0] src_sample;

    amis_ram #(
        .WIDTH (SampleW),
        .DEPTH (NbDepth)
    ) u_nb_ram (
        .clk     (clk),
        .wr_en   (nb_wr_en),
        .wr_addr (NbAw'(req_word.index)),
        .wr_data (req_word.value),
        .rd_en   (rd_issue),
        .rd_addr (nb_idx[NbAw-1:0]),
        .rd_data (nb_sample)
    );

    amis_ram #(
        .WIDTH (SampleW),
        .DEPTH (SrcDepth)
    ) u_src_ram (
        .clk     (clk),
        .wr_en   (src_wr_en),
        .wr_addr (SrcAw'(req_word.index)),
        .wr_data (req_word.value),
        .rd_en   (rd_issue),
        .rd_addr (pix_reg),
        .rd_data (src_sample)
    );

    // ------------------------------------------------------------------
    // Cost and running best
    // ------------------------------------------------------------------
    logic [SampleW-1:0] abs_diff;
    logic [CostW-1:0]   cost_sat;
    logic               cost_better;
    logic [CostW-1:0]   best_cost_upd;
    logic [MfW-1:0]     best_mode_upd;
    logic               last_pix;
    logic               last_mode;

    assign abs_diff      = (nb_sample > src_sample) ? (nb_sample - src_sample)
                                                    : (src_sample - nb_sample);
    assign cost_sat      = (32'(sum_reg) > 32'(amis_pkg::CostMax)) ? amis_pkg::CostMax
                                                                   : CostW'(sum_reg);
    assign cost_better   = cost_sat < best_cost_reg;
    assign best_cost_upd = cost_better ? cost_sat : best_cost_reg;
    assign best_mode_upd = cost_better ? MfW'(mode_reg) : best_mode_reg;
    assign last_pix      = (x_reg == CoordLast) && (y_reg == CoordLast);
    assign last_mode     = (mode_reg == ModeLast);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            amis_pkg::ST_IDLE:     state_next = start_take ? amis_pkg::ST_MUL_COT
                                                           : amis_pkg::ST_IDLE;
            amis_pkg::ST_MUL_COT:  state_next = amis_pkg::ST_MUL_TAN;
            amis_pkg::ST_MUL_TAN:  state_next = amis_pkg::ST_ADDR;
            amis_pkg::ST_ADDR:     state_next = amis_pkg::ST_ACC;
            amis_pkg::ST_ACC:      state_next = last_pix ? amis_pkg::ST_MODE_END
                                                         : amis_pkg::ST_MUL_COT;
            amis_pkg::ST_MODE_END: state_next = last_mode ? amis_pkg::ST_IDLE
                                                          : amis_pkg::ST_MUL_COT;
            default:               state_next = amis_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        req_stall   = 1'b1;
        mul_tan_sel = 1'b0;
        rd_issue    = 1'b0;
        case (state_reg)
            amis_pkg::ST_IDLE:
            begin
                // a new search waits until the previous response is taken
                req_stall = rsp_valid_reg && (req_word.kind == amis_pkg::KIND_START);
            end
            amis_pkg::ST_MUL_COT: mul_tan_sel = 1'b0;
            amis_pkg::ST_MUL_TAN: mul_tan_sel = 1'b1;
            amis_pkg::ST_ADDR:    rd_issue    = 1'b1;
            amis_pkg::ST_ACC:     rd_issue    = 1'b0;
            amis_pkg::ST_MODE_END: rd_issue   = 1'b0;
            default:              req_stall   = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next      = mode_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        pix_next       = pix_reg;
        prod_next      = prod_reg;
        i0_next        = i0_reg;
        sum_next       = sum_reg;
        best_mode_next = best_mode_reg;
        best_cost_next = best_cost_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;

        // response leaves
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            amis_pkg::ST_IDLE:
            begin
                if (start_take)
                begin
                    mode_next      = '0;
                    x_next         = '0;
                    y_next         = '0;
                    pix_next       = '0;
                    sum_next       = '0;
                    best_mode_next = '0;
                    best_cost_next = amis_pkg::CostMax;
                end
            end
            amis_pkg::ST_MUL_COT:
            begin
                prod_next = mul_out;
            end
            amis_pkg::ST_MUL_TAN:
            begin
                i0_next   = x_s + prod_trunc;
                prod_next = mul_out;
            end
            amis_pkg::ST_ADDR:
            begin
                i0_next = i0_reg;
            end
            amis_pkg::ST_ACC:
            begin
                sum_next = sum_reg + SumW'(abs_diff);
                if (last_pix)
                begin
                    x_next   = '0;
                    y_next   = '0;
                    pix_next = '0;
                end
                else
                begin
                    pix_next = pix_reg + 1'b1;
                    if (x_reg == CoordLast)
                    begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                end
            end
            amis_pkg::ST_MODE_END:
            begin
                best_cost_next = best_cost_upd;
                best_mode_next = best_mode_upd;
                sum_next       = '0;
                if (last_mode)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_word_next.best_mode = best_mode_upd;
                    rsp_word_next.best_cost = best_cost_upd;
                end
                else
                begin
                    mode_next = mode_reg + 1'b1;
                end
            end
            default:
            begin
                sum_next = sum_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and status registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amis_pkg::ST_IDLE;
            mode_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            pix_reg       <= '0;
            best_mode_reg <= '0;
            best_cost_reg <= amis_pkg::CostMax;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            pix_reg       <= pix_next;
            best_mode_reg <= best_mode_next;
            best_cost_reg <= best_cost_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        i0_reg       <= i0_next;
        sum_reg      <= sum_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rsp_from_mode_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == amis_pkg::ST_MODE_END))
        else $error("response raised outside the final mode compare");

    a_acc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == amis_pkg::ST_ACC) |-> $past(state_reg == amis_pkg::ST_ADDR))
        else $error("accumulate without a preceding RAM read");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start_take |=> (state_reg == amis_pkg::ST_MUL_COT) && (mode_reg == '0)
                       && (sum_reg == '0) && (best_cost_reg == amis_pkg::CostMax))
        else $error("search start did not clear the running state");

    a_no_start_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        start_take |-> !rsp_valid_reg)
        else $error("search started while a response was pending");

endmodule

[tb/tb_angular_intra_mode_search.sv]
// Self-checking testbench for angular_intra_mode_search: loads neighbor and source
// samples, starts mode searches and checks each best mode and SAD against a local model.
// Depends on amis_pkg and the angular_intra_mode_search RTL.
module tb_angular_intra_mode_search;

    localparam int BLOCK_N   = 16;
    localparam int MODES     = 32;
    localparam int NB_DEPTH  = 4 * BLOCK_N;
    localparam int SRC_DEPTH = BLOCK_N * BLOCK_N;

    localparam longint PI_FIXED   = 64'sd3373259426;  // pi in Q30
    localparam longint ONE_FIXED  = 64'sd1073741824;  // 1.0 in Q30
    localparam longint Q16_UNIT   = 64'sd65536;
    localparam longint TAN_CLAMP  = 64 * Q16_UNIT;
    localparam int unsigned SAD_CEIL = 65535;

    // kind code with no function in the block
    localparam amis_pkg::kind_t KIND_UNUSED = amis_pkg::kind_t'(2'b11);

    localparam int RANDOM_ROUNDS  = 26;
    localparam int PRESSURE_ROUND = 12;
    localparam int PRESSURE_HOLD  = 40000;
    localparam int TAIL_CYCLES    = 64;
    localparam int unsigned CYCLE_LIMIT = 5000000;

    // Mirror of the sample stores plus the mode search arithmetic
    class search_scoreboard;
        logic [7:0]          neighbor_mem [NB_DEPTH];
        logic [7:0]          source_mem [SRC_DEPTH];
        longint              tan_tab [MODES];
        longint              cot_tab [MODES];
        amis_pkg::rsp_word_t expected_best [$];
        int                  errors;

        function new();
            longint r;
            errors = 0;
            for (int m = 0; m < MODES; m++)
            begin
                r = 4 * m - MODES;
                tan_tab[m] = tan_fixed(r);
                cot_tab[m] = tan_fixed(2 * MODES - r);
            end
        endfunction

        // tan(k*pi/(4*MODES)) as Q16, Taylor series in Q30, clamped to +-64
        function longint tan_fixed(longint k);
            longint quarter;
            longint period;
            longint x;
            longint x2;
            longint term;
            longint s;
            longint c;
            longint r;
            bit     neg;
            quarter = 2 * MODES;
            period  = 4 * MODES;
            neg     = 1'b0;
            k = k % period;
            if (k <= -quarter)
                k = k + period;
            if (k > quarter)
                k = k - period;
            if (k < 0)
            begin
                neg = 1'b1;
                k = -k;
            end
            if (k == 0)
                return 0;
            if (k == quarter)
                return neg ? -TAN_CLAMP : TAN_CLAMP;
            x  = (k * PI_FIXED) / period;
            x2 = (x * x) / ONE_FIXED;
            // sine
            s = 0;
            term = x;
            for (int n = 1; n <= 21; n += 2)
            begin
                if ((((n - 1) / 2) % 2) == 0)
                    s = s + term;
                else
                    s = s - term;
                term = (term * x2) / ONE_FIXED;
                term = term / (longint'(n + 1) * longint'(n + 2));
            end
            // cosine
            c = 0;
            term = ONE_FIXED;
            for (int n = 0; n <= 20; n += 2)
            begin
                if (((n / 2) % 2) == 0)
                    c = c + term;
                else
                    c = c - term;
                term = (term * x2) / ONE_FIXED;
                term = term / (longint'(n + 1) * longint'(n + 2));
            end
            if (s < 0)
                s = 0;
            if ((c <= 0) || (s >= 64 * c))
                r = TAN_CLAMP;
            else
            begin
                r = (s * Q16_UNIT + c / 2) / c;
                if (r > TAN_CLAMP)
                    r = TAN_CLAMP;
            end
            return neg ? -r : r;
        endfunction

        // neighbor entry that predicts pixel (x,y) under mode m
        function int predicted_index(int m, int x, int y);
            longint i0;
            longint i1;
            longint idx;
            i0 = x + (longint'(y) * cot_tab[m]) / Q16_UNIT;
            i1 = y - (longint'(x) * tan_tab[m]) / Q16_UNIT;
            if ((i0 >= 0) && (i0 <= 2 * BLOCK_N - 1))
                idx = 2 * BLOCK_N + i0;
            else
            begin
                idx = 2 * BLOCK_N - i1;
                if (idx < 0)
                    idx = 0;
                if (idx > NB_DEPTH - 1)
                    idx = NB_DEPTH - 1;
            end
            return int'(idx);
        endfunction

        function int unsigned sad_of_mode(int m);
            int unsigned sum;
            int          p;
            int          q;
            sum = 0;
            for (int y = 0; y < BLOCK_N; y++)
            begin
                for (int x = 0; x < BLOCK_N; x++)
                begin
                    p = neighbor_mem[predicted_index(m, x, y)];
                    q = source_mem[y * BLOCK_N + x];
                    sum += (p > q) ? (p - q) : (q - p);
                end
            end
            return (sum > SAD_CEIL) ? SAD_CEIL : sum;
        endfunction

        // first mode with the strictly lowest SAD; cleared for every search
        function amis_pkg::rsp_word_t best_of_modes();
            amis_pkg::rsp_word_t best;
            int unsigned         cost;
            best.best_mode = '0;
            best.best_cost = '1;
            for (int m = 0; m < MODES; m++)
            begin
                cost = sad_of_mode(m);
                if (cost < best.best_cost)
                begin
                    best.best_cost = cost[amis_pkg::CostW-1:0];
                    best.best_mode = m[amis_pkg::ModeFieldW-1:0];
                end
            end
            return best;
        endfunction

        task flag_mismatch(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            errors++;
        endtask

        // accepted request word
        function void note_word(amis_pkg::req_word_t w);
            case (w.kind)
                amis_pkg::KIND_NEIGHBOR:
                begin
                    if (w.index < NB_DEPTH)
                        neighbor_mem[w.index] = w.value;
                end
                amis_pkg::KIND_SOURCE:
                begin
                    if (w.index < SRC_DEPTH)
                        source_mem[w.index] = w.value;
                end
                amis_pkg::KIND_START:
                    expected_best.push_back(best_of_modes());
                default:
                    ;
            endcase
        endfunction

        // accepted response word against the oldest expectation
        task check_word(amis_pkg::rsp_word_t got);
            amis_pkg::rsp_word_t want;
            if (expected_best.size() == 0)
            begin
                flag_mismatch($sformatf("response with none pending: mode %0d cost %0d",
                                        got.best_mode, got.best_cost));
                return;
            end
            want = expected_best.pop_front();
            if (got.best_mode !== want.best_mode)
                flag_mismatch($sformatf("best_mode got %0d, expected %0d",
                                        got.best_mode, want.best_mode));
            if (got.best_cost !== want.best_cost)
                flag_mismatch($sformatf("best_cost got %0d, expected %0d",
                                        got.best_cost, want.best_cost));
        endtask
    endclass

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    amis_pkg::req_word_t req_word  = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    amis_pkg::rsp_word_t rsp_word;

    search_scoreboard board = new();
    bit          idle_on     = 1'b1;
    bit          pressure_req = 1'b0;
    int unsigned cycle_count = 0;

    angular_intra_mode_search #(
        .BLOCK_SIZE (BLOCK_N),
        .MODE_COUNT (MODES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic amis_pkg::req_word_t make_word(amis_pkg::kind_t kind, int idx, int val);
        amis_pkg::req_word_t w;
        w.kind  = kind;
        w.index = idx[amis_pkg::IndexW-1:0];
        w.value = val[amis_pkg::SampleW-1:0];
        return w;
    endfunction

    function automatic int random_sample();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    // mostly in-range loads, a few dropped writes and unused kinds
    function automatic amis_pkg::req_word_t random_load_word();
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if ($urandom_range(0, 9) == 0)
                idx = $urandom_range(NB_DEPTH, 255);
            else
                idx = $urandom_range(0, NB_DEPTH - 1);
            return make_word(amis_pkg::KIND_NEIGHBOR, idx, random_sample());
        end
        if (pick < 92)
            return make_word(amis_pkg::KIND_SOURCE, $urandom_range(0, SRC_DEPTH - 1),
                             random_sample());
        return make_word(KIND_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    // Offer one word, hold it until accepted
    task automatic send_word(amis_pkg::req_word_t w);
        if (idle_on && ($urandom_range(0, 7) == 0))
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_word(w);
    endtask

    task automatic send_start();
        send_word(make_word(amis_pkg::KIND_START, $urandom_range(0, 255),
                            $urandom_range(0, 255)));
    endtask

    // Fresh neighbors, source drawn along one mode's direction with a little noise
    task automatic load_directional_block(int mode);
        int v;
        for (int i = 0; i < NB_DEPTH; i++)
            send_word(make_word(amis_pkg::KIND_NEIGHBOR, i, $urandom_range(0, 255)));
        for (int y = 0; y < BLOCK_N; y++)
        begin
            for (int x = 0; x < BLOCK_N; x++)
            begin
                v = int'(board.neighbor_mem[board.predicted_index(mode, x, y)]);
                v = v + $urandom_range(0, 6) - 3;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                send_word(make_word(amis_pkg::KIND_SOURCE, y * BLOCK_N + x, v));
            end
        end
    endtask

    // Response side: check, then random stall bursts and the one long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                board.check_word(rsp_word);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    rsp_stall <= 1'b0;
            end
            else if (pressure_req)
            begin
                pressure_req = 1'b0;
                stall_left = PRESSURE_HOLD;
                rsp_stall <= 1'b1;
            end
            else if (idle_on && ($urandom_range(0, 11) == 0))
            begin
                stall_left = $urandom_range(1, 16);
                rsp_stall <= 1'b1;
            end
        end
    end

    // Stimulus
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flat block: every mode costs zero, lowest mode wins the tie
        for (int i = 0; i < NB_DEPTH; i++)
            send_word(make_word(amis_pkg::KIND_NEIGHBOR, i, 0));
        for (int i = 0; i < SRC_DEPTH; i++)
            send_word(make_word(amis_pkg::KIND_SOURCE, i, 0));
        send_start();

        // full-scale neighbors against a zero source: largest cost for all modes
        for (int i = 0; i < NB_DEPTH; i++)
            send_word(make_word(amis_pkg::KIND_NEIGHBOR, i, 255));
        send_start();

        // dropped writes, unused kind, corner pixels, back-to-back starts
        send_word(make_word(amis_pkg::KIND_NEIGHBOR, NB_DEPTH, 0));
        send_word(make_word(amis_pkg::KIND_NEIGHBOR, 255, 0));
        send_word(make_word(KIND_UNUSED, 255, 255));
        send_word(make_word(KIND_UNUSED, 0, 0));
        send_word(make_word(amis_pkg::KIND_SOURCE, SRC_DEPTH - 1, 255));
        send_word(make_word(amis_pkg::KIND_SOURCE, 0, 255));
        send_word(make_word(amis_pkg::KIND_NEIGHBOR, 0, 0));
        send_word(make_word(amis_pkg::KIND_NEIGHBOR, NB_DEPTH - 1, 0));
        send_start();
        send_start();

        // random rounds of loads, each closed by a search
        for (int round = 0; round < RANDOM_ROUNDS; round++)
        begin
            idle_on = (round < RANDOM_ROUNDS - 4) && ($urandom_range(0, 3) != 0);
            if ((round % 13) == 1)
                load_directional_block($urandom_range(0, MODES - 1));
            else
                repeat ($urandom_range(4, 16)) send_word(random_load_word());
            if (round == PRESSURE_ROUND)
                pressure_req = 1'b1;
            send_start();
        end
        req_valid <= 1'b0;

        while (board.expected_best.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
